@@ design/spr_pkg.sv @@
// shared types and codes for the slotted page record store
package spr_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_UPDATE = 2'd2,
		OP_READ   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		STS_DONE         = 3'd0,
		STS_NO_SPACE     = 3'd1,
		STS_NO_SLOT      = 3'd2,
		STS_ALREADY_FREE = 3'd3,
		STS_INDEX_RANGE  = 3'd4,
		STS_BYTE_TAKEN   = 3'd5
	} status_t;

	typedef struct packed {
		opcode_t      opcode;
		logic [7:0]   slot_id;
		logic [12:0]  record_length;
		logic [11:0]  byte_index;
		logic [7:0]   data_byte;
		logic         last_byte;
	} req_t;

	typedef struct packed {
		status_t      status;
		logic [7:0]   result_slot;
		logic [7:0]   read_byte;
		logic [12:0]  free_bytes;
		logic [8:0]   slot_total;
	} rsp_t;

endpackage

@@ design/spr_req_if.sv @@
// request channel: one operation item per transfer
interface spr_req_if import spr_pkg::*;;
	logic valid;
	logic ready;
	req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/spr_rsp_if.sv @@
// response channel: one result item per transfer
interface spr_rsp_if import spr_pkg::*;;
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/slotted_page_record_store.sv @@
// slotted page record store: directory, page memory and operation sequencer
// an open insert's streamed byte passes dispatch and the byte write state.
// a first insert byte walks the directory before the space check and slot write.
// erase walks the directory, moves the bytes below the record up, then walks it again
// to fix offsets. update reads the entry and writes the byte; read adds a page read.
// one item at a time; reset clears counters, flags and used bits, memories keep contents.
module slotted_page_record_store import spr_pkg::*; #(
	parameter int PAGE_BYTES   = 4096,
	parameter int MAX_SLOTS    = 256,
	parameter int HEADER_BYTES = 16,
	parameter int SLOT_BYTES   = 24
) (
	input  logic clk,
	input  logic arst_n,
	spr_req_if.sink   req,
	spr_rsp_if.source rsp
);

	localparam int OW = $clog2(PAGE_BYTES + 1);
	localparam int PW = $clog2(PAGE_BYTES);
	localparam int SW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int EW = ((OW > 13) ? OW : 13) + 1;
	localparam int IW = ((CW > 8) ? CW : 8) + 1;

	typedef enum logic [12:0] {
		FSM_IDLE   = 13'b0000000000001,
		FSM_DISP   = 13'b0000000000010,
		FSM_SCAN   = 13'b0000000000100,
		FSM_INS    = 13'b0000000001000,
		FSM_BYTE   = 13'b0000000010000,
		FSM_RDSLOT = 13'b0000000100000,
		FSM_ERS    = 13'b0000001000000,
		FSM_MOVE   = 13'b0000010000000,
		FSM_FIX    = 13'b0000100000000,
		FSM_ERSF   = 13'b0001000000000,
		FSM_ACC    = 13'b0010000000000,
		FSM_RDB    = 13'b0100000000000,
		FSM_DONE   = 13'b1000000000000
	} fsm_t;

	fsm_t state_q;

	// latched request
	req_t          req_q;

	// page and directory state
	logic [MAX_SLOTS-1:0] used_q;
	logic [CW-1:0] cnt_q;
	logic [OW-1:0] free_q;
	logic [OW-1:0] wp_q;
	logic [OW-1:0] end_q;
	logic [SW-1:0] pend_q;
	logic          act_q;
	logic          ref_q;

	// work registers
	logic [CW-1:0] ctr_q;
	logic          sv_s1;
	logic [SW-1:0] six_s1;
	logic [OW-1:0] doff_q;
	logic [OW-1:0] dlen_q;
	logic [OW-1:0] mv_a_q;
	logic          mv_v_s1;
	logic [EW-1:0] dst_s1;

	// result
	status_t       sts_q;
	logic [7:0]    rslot_q;
	logic [7:0]    rbyte_q;
	rsp_t          rsp_q;
	logic          out_v_q;

	// memories
	logic [7:0]    page_mem [PAGE_BYTES];
	logic [OW-1:0] off_mem [MAX_SLOTS];
	logic [OW-1:0] len_mem [MAX_SLOTS];
	logic [7:0]    pg_rd_q;
	logic [OW-1:0] off_rd_q;
	logic [OW-1:0] len_rd_q;

	logic [PW-1:0] pg_ra, pg_wa;
	logic          pg_we;
	logic [7:0]    pg_wd;
	logic [SW-1:0] dir_ra, dir_wa;
	logic          off_we, len_we;
	logic [OW-1:0] off_wd;

	// scan unit
	logic          sc_clr;
	logic [OW-1:0] sc_low;
	logic          sc_hole_v;
	logic [SW-1:0] sc_hole;

	logic [SW-1:0] sid_ix;
	logic          sid_ok;
	logic [EW-1:0] need;
	logic          refuse;
	logic [OW-1:0] new_off;
	logic [SW-1:0] ins_id;
	logic          bw_ok;
	logic [EW-1:0] acc_addr;
	logic          move_go;
	logic          fix_hit;
	logic          scan_more;
	logic          is_last;

	assign sid_ix   = SW'(req_q.slot_id);
	assign sid_ok   = (IW'(req_q.slot_id) < IW'(cnt_q)) && (IW'(req_q.slot_id) < IW'(MAX_SLOTS));
	assign need     = EW'(req_q.record_length) + (sc_hole_v ? EW'(0) : EW'(SLOT_BYTES));
	assign refuse   = (need > EW'(free_q)) || (!sc_hole_v && cnt_q >= CW'(MAX_SLOTS))
		|| (EW'(req_q.record_length) > EW'(sc_low));
	assign new_off  = OW'(EW'(sc_low) - EW'(req_q.record_length));
	assign ins_id   = sc_hole_v ? sc_hole : SW'(cnt_q);
	assign bw_ok    = (wp_q < end_q) && (EW'(wp_q) < EW'(PAGE_BYTES));
	assign acc_addr = EW'(off_rd_q) + EW'(req_q.byte_index);
	assign move_go  = (dlen_q != '0) && (mv_a_q > sc_low);
	assign scan_more = ctr_q < cnt_q;
	assign is_last  = req_q.last_byte;
	// records below the freed one, and empty records sitting at its offset, move up
	assign fix_hit  = sv_s1 && (six_s1 != sid_ix) && used_q[six_s1]
		&& ((off_rd_q < doff_q) || (off_rd_q == doff_q && len_rd_q == '0));

	assign sc_clr = (state_q == FSM_DISP) || (state_q == FSM_ERS);

	spr_scan #(
		.OW       (OW),
		.SW       (SW),
		.LOW_INIT (PAGE_BYTES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (sc_clr),
		.ent_v    (sv_s1 && state_q == FSM_SCAN),
		.ent_idx  (six_s1),
		.ent_used (used_q[six_s1]),
		.ent_off  (off_rd_q),
		.low      (sc_low),
		.hole_v   (sc_hole_v),
		.hole     (sc_hole)
	);

	// memory port selection
	always_comb begin
		pg_ra  = PW'(acc_addr);
		pg_we  = 1'b0;
		pg_wa  = PW'(wp_q);
		pg_wd  = req_q.data_byte;
		dir_ra = sid_ix;
		dir_wa = ins_id;
		off_we = 1'b0;
		len_we = 1'b0;
		off_wd = new_off;
		unique case (state_q)
			FSM_SCAN, FSM_FIX: begin
				dir_ra = SW'(ctr_q);
				if (state_q == FSM_FIX && fix_hit) begin
					off_we = 1'b1;
					dir_wa = six_s1;
					off_wd = off_rd_q + dlen_q;
				end
			end
			FSM_INS: begin
				if (!refuse) begin
					off_we = 1'b1;
					len_we = 1'b1;
					if (req_q.record_length != '0) begin
						pg_we = 1'b1;
						pg_wa = PW'(new_off);
					end
				end
			end
			FSM_BYTE: begin
				pg_we = bw_ok;
			end
			FSM_MOVE: begin
				pg_ra = PW'(mv_a_q - OW'(1));
				pg_wa = PW'(dst_s1);
				pg_wd = pg_rd_q;
				pg_we = mv_v_s1 && (dst_s1 < EW'(PAGE_BYTES));
			end
			FSM_ACC: begin
				pg_wa = PW'(acc_addr);
				pg_we = (req_q.opcode == OP_UPDATE) && (EW'(req_q.byte_index) < EW'(len_rd_q))
					&& (acc_addr < EW'(PAGE_BYTES));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pg_we) begin
			page_mem[pg_wa] <= pg_wd;
		end
		pg_rd_q <= page_mem[pg_ra];
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[dir_wa] <= off_wd;
		end
		if (len_we) begin
			len_mem[dir_wa] <= OW'(req_q.record_length);
		end
		off_rd_q <= off_mem[dir_ra];
		len_rd_q <= len_mem[dir_ra];
	end

	assign req.ready   = (state_q == FSM_IDLE);
	assign rsp.valid   = out_v_q;
	assign rsp.payload = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			used_q  <= '0;
			cnt_q   <= '0;
			free_q  <= OW'(PAGE_BYTES - HEADER_BYTES);
			wp_q    <= '0;
			end_q   <= '0;
			pend_q  <= '0;
			act_q   <= 1'b0;
			ref_q   <= 1'b0;
			ctr_q   <= '0;
			sv_s1   <= 1'b0;
			mv_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && rsp.ready && state_q != FSM_DONE) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				FSM_IDLE: begin
					if (req.valid) begin
						state_q <= FSM_DISP;
					end
				end
				FSM_DISP: begin
					rbyte_q <= '0;
					ctr_q   <= '0;
					sv_s1   <= 1'b0;
					mv_v_s1 <= 1'b0;
					if (req_q.opcode == OP_INSERT) begin
						if (ref_q) begin
							sts_q   <= STS_NO_SPACE;
							rslot_q <= '0;
							if (is_last) begin
								ref_q <= 1'b0;
							end
							state_q <= FSM_DONE;
						end else if (act_q) begin
							state_q <= FSM_BYTE;
						end else begin
							state_q <= FSM_SCAN;
						end
					end else begin
						// any other operation closes an open insert
						act_q   <= 1'b0;
						ref_q   <= 1'b0;
						rslot_q <= req_q.slot_id;
						if (!sid_ok) begin
							sts_q   <= STS_NO_SLOT;
							state_q <= FSM_DONE;
						end else if (!used_q[sid_ix]) begin
							sts_q   <= STS_ALREADY_FREE;
							state_q <= FSM_DONE;
						end else begin
							state_q <= FSM_RDSLOT;
						end
					end
				end
				FSM_SCAN: begin
					if (scan_more) begin
						sv_s1  <= 1'b1;
						six_s1 <= SW'(ctr_q);
						ctr_q  <= ctr_q + CW'(1);
					end else begin
						sv_s1 <= 1'b0;
						if (!sv_s1) begin
							if (req_q.opcode == OP_ERASE) begin
								mv_a_q  <= doff_q;
								state_q <= FSM_MOVE;
							end else begin
								state_q <= FSM_INS;
							end
						end
					end
				end
				FSM_INS: begin
					if (refuse) begin
						sts_q   <= STS_NO_SPACE;
						rslot_q <= '0;
						ref_q   <= !is_last;
					end else begin
						if (!sc_hole_v) begin
							cnt_q <= cnt_q + CW'(1);
						end
						free_q          <= OW'(EW'(free_q) - need);
						used_q[ins_id]  <= 1'b1;
						pend_q          <= ins_id;
						end_q           <= sc_low;
						rslot_q         <= 8'(ins_id);
						if (req_q.record_length == '0) begin
							wp_q  <= new_off;
							sts_q <= STS_DONE;
						end else begin
							wp_q  <= new_off + OW'(1);
							sts_q <= is_last ? STS_DONE : STS_BYTE_TAKEN;
							act_q <= !is_last;
						end
					end
					state_q <= FSM_DONE;
				end
				FSM_BYTE: begin
					rslot_q <= 8'(pend_q);
					if (bw_ok) begin
						wp_q  <= wp_q + OW'(1);
						sts_q <= is_last ? STS_DONE : STS_BYTE_TAKEN;
					end else begin
						sts_q <= STS_INDEX_RANGE;
					end
					if (is_last) begin
						act_q <= 1'b0;
					end
					state_q <= FSM_DONE;
				end
				FSM_RDSLOT: begin
					state_q <= (req_q.opcode == OP_ERASE) ? FSM_ERS : FSM_ACC;
				end
				FSM_ERS: begin
					doff_q  <= off_rd_q;
					dlen_q  <= len_rd_q;
					ctr_q   <= '0;
					sv_s1   <= 1'b0;
					state_q <= FSM_SCAN;
				end
				FSM_MOVE: begin
					// read one byte, write it dlen higher on the next cycle
					if (move_go) begin
						mv_v_s1 <= 1'b1;
						dst_s1  <= EW'(mv_a_q) - EW'(1) + EW'(dlen_q);
						mv_a_q  <= mv_a_q - OW'(1);
					end else begin
						mv_v_s1 <= 1'b0;
						if (!mv_v_s1) begin
							ctr_q   <= '0;
							sv_s1   <= 1'b0;
							state_q <= FSM_FIX;
						end
					end
				end
				FSM_FIX: begin
					if (scan_more) begin
						sv_s1  <= 1'b1;
						six_s1 <= SW'(ctr_q);
						ctr_q  <= ctr_q + CW'(1);
					end else begin
						sv_s1 <= 1'b0;
						if (!sv_s1) begin
							state_q <= FSM_ERSF;
						end
					end
				end
				FSM_ERSF: begin
					used_q[sid_ix] <= 1'b0;
					if (IW'(req_q.slot_id) + IW'(1) == IW'(cnt_q)) begin
						cnt_q  <= cnt_q - CW'(1);
						free_q <= free_q + dlen_q + OW'(SLOT_BYTES);
					end else begin
						free_q <= free_q + dlen_q;
					end
					sts_q   <= STS_DONE;
					state_q <= FSM_DONE;
				end
				FSM_ACC: begin
					if (EW'(req_q.byte_index) >= EW'(len_rd_q)) begin
						sts_q   <= STS_INDEX_RANGE;
						state_q <= FSM_DONE;
					end else begin
						sts_q <= STS_DONE;
						if (req_q.opcode == OP_READ && acc_addr < EW'(PAGE_BYTES)) begin
							state_q <= FSM_RDB;
						end else begin
							state_q <= FSM_DONE;
						end
					end
				end
				FSM_RDB: begin
					rbyte_q <= pg_rd_q;
					state_q <= FSM_DONE;
				end
				FSM_DONE: begin
					if (!out_v_q || rsp.ready) begin
						out_v_q <= 1'b1;
						state_q <= FSM_IDLE;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && req.valid) begin
			req_q <= req.payload;
		end
		if (state_q == FSM_DONE && (!out_v_q || rsp.ready)) begin
			rsp_q.status      <= sts_q;
			rsp_q.result_slot <= rslot_q;
			rsp_q.read_byte   <= rbyte_q;
			rsp_q.free_bytes  <= 13'(free_q);
			rsp_q.slot_total  <= 9'(cnt_q);
		end
	end

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(act_q && ref_q))
		else $error("insert both open and refused");
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_SLOTS))
		else $error("slot count beyond directory size");
	a_free_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= OW'(PAGE_BYTES - HEADER_BYTES))
		else $error("free count beyond usable page");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");
	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DONE && !out_v_q |=> out_v_q && state_q == FSM_IDLE)
		else $error("finished result not presented");

endmodule

@@ design/spr_scan.sv @@
// directory walk unit: lowest used offset and first free slot
module spr_scan #(
	parameter int OW = 13,
	parameter int SW = 8,
	parameter int LOW_INIT = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          ent_v,
	input  logic [SW-1:0] ent_idx,
	input  logic          ent_used,
	input  logic [OW-1:0] ent_off,
	output logic [OW-1:0] low,
	output logic          hole_v,
	output logic [SW-1:0] hole
);

	logic [OW-1:0] low_q;
	logic          hole_v_q;
	logic [SW-1:0] hole_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= OW'(LOW_INIT);
			hole_v_q <= 1'b0;
			hole_q   <= '0;
		end else if (clr) begin
			low_q    <= OW'(LOW_INIT);
			hole_v_q <= 1'b0;
			hole_q   <= '0;
		end else if (ent_v) begin
			if (ent_used && ent_off < low_q) begin
				low_q <= ent_off;
			end
			if (!ent_used && !hole_v_q) begin
				hole_v_q <= 1'b1;
				hole_q   <= ent_idx;
			end
		end
	end

	assign low    = low_q;
	assign hole_v = hole_v_q;
	assign hole   = hole_q;

	a_low_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		low_q <= OW'(LOW_INIT))
		else $error("lowest offset beyond page end");
	a_hole_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		hole_v_q && !clr |=> hole_v_q && $stable(hole_q))
		else $error("first free slot changed during walk");
	a_clr_resets: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> !hole_v_q)
		else $error("walk start did not clear free slot");

endmodule

@@ test/tb_slotted_page_record_store.sv @@
// testbench for the slotted page record store: random and directed operations against a page model
module tb_slotted_page_record_store import spr_pkg::*;;

	localparam int PAGE = 4096;
	localparam int SLOTS = 256;
	localparam int HDR = 16;
	localparam int DIR_ENTRY = 24;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	spr_req_if req_ch();
	spr_rsp_if rsp_ch();

	slotted_page_record_store u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// page image kept by the testbench
	logic [7:0] pg_mem [PAGE];
	bit pg_known [PAGE];
	int s_off [SLOTS];
	int s_len [SLOTS];
	bit s_used [SLOTS];
	int n_slots;
	int n_free;
	int wr_ptr;
	int open_slot;
	bit ins_open;
	bit ins_refused;

	req_t stim_items [$];
	rsp_t stim_outcomes [$];
	rsp_t outcome_q [$];
	rsp_t offered_outcome;
	int n_items;
	int n_total;
	int n_sent;
	int n_got;
	int fails;
	int idle_cycles;

	function automatic int lowest_record();
		int low;
		low = PAGE;
		for (int i = 0; i < n_slots; i++)
			if (s_used[i] && s_off[i] < low) low = s_off[i];
		return low;
	endfunction

	function automatic void drop_record(int id);
		int doff, dlen, low;
		doff = s_off[id];
		dlen = s_len[id];
		low = lowest_record();
		// shift everything below the freed record up by its length
		if (dlen > 0 && doff > low) begin
			for (int a = doff; a > low; a--) begin
				if (a - 1 + dlen < PAGE) begin
					pg_mem[a - 1 + dlen] = pg_mem[a - 1];
					pg_known[a - 1 + dlen] = pg_known[a - 1];
				end
			end
		end
		for (int j = 0; j < n_slots; j++) begin
			if (j != id && s_used[j] &&
			    (s_off[j] < doff || (s_off[j] == doff && s_len[j] == 0)))
				s_off[j] += dlen;
		end
		s_used[id] = 1'b0;
		if (id + 1 == n_slots) begin
			n_slots--;
			n_free += dlen + DIR_ENTRY;
		end else begin
			n_free += dlen;
		end
	endfunction

	function automatic rsp_t page_model_step(req_t r);
		rsp_t o;
		int st, rslot, rbyte, hole, need, low, id, len, sid, idx, stop;
		bit ok;
		st = STS_DONE;
		rslot = 0;
		rbyte = 0;
		len = r.record_length;
		sid = r.slot_id;
		idx = r.byte_index;
		if (r.opcode == OP_INSERT) begin
			if (!ins_open && !ins_refused) begin
				ok = 1'b0;
				hole = -1;
				for (int i = 0; i < n_slots; i++)
					if (!s_used[i] && hole < 0) hole = i;
				need = len + (hole < 0 ? DIR_ENTRY : 0);
				low = lowest_record();
				if (!(need > n_free || (hole < 0 && n_slots >= SLOTS) || len > low)) begin
					id = hole < 0 ? n_slots : hole;
					if (hole < 0) n_slots++;
					n_free -= need;
					s_off[id] = low - len;
					s_len[id] = len;
					s_used[id] = 1'b1;
					ok = 1'b1;
				end
				if (!ok) begin
					st = STS_NO_SPACE;
					ins_refused = !r.last_byte;
				end else begin
					open_slot = id;
					wr_ptr = s_off[id];
					rslot = id;
					if (len != 0) ins_open = 1'b1;
				end
			end else if (ins_refused) begin
				st = STS_NO_SPACE;
				if (r.last_byte) ins_refused = 1'b0;
			end
			if (ins_open) begin
				stop = s_off[open_slot] + s_len[open_slot];
				rslot = open_slot;
				if (wr_ptr < stop && wr_ptr < PAGE) begin
					pg_mem[wr_ptr] = r.data_byte;
					pg_known[wr_ptr] = 1'b1;
					wr_ptr++;
					st = r.last_byte ? STS_DONE : STS_BYTE_TAKEN;
				end else begin
					st = STS_INDEX_RANGE;
				end
				if (r.last_byte) ins_open = 1'b0;
			end
		end else begin
			// any other operation closes an open or refused insert first
			ins_open = 1'b0;
			ins_refused = 1'b0;
			rslot = sid;
			if (sid >= n_slots) begin
				st = STS_NO_SLOT;
			end else if (!s_used[sid]) begin
				st = STS_ALREADY_FREE;
			end else if (r.opcode == OP_ERASE) begin
				drop_record(sid);
			end else if (idx >= s_len[sid]) begin
				st = STS_INDEX_RANGE;
			end else if (s_off[sid] + idx < PAGE) begin
				if (r.opcode == OP_UPDATE) begin
					pg_mem[s_off[sid] + idx] = r.data_byte;
					pg_known[s_off[sid] + idx] = 1'b1;
				end else begin
					rbyte = pg_mem[s_off[sid] + idx];
				end
			end
		end
		o.status = status_t'(st);
		o.result_slot = rslot[7:0];
		o.read_byte = rbyte[7:0];
		o.free_bytes = n_free[12:0];
		o.slot_total = n_slots[8:0];
		return o;
	endfunction

	task automatic queue_item(opcode_t op, int sid, int len, int idx, int db, bit last);
		req_t r;
		int a;
		r.opcode = op;
		r.slot_id = sid[7:0];
		r.record_length = len[12:0];
		r.byte_index = idx[11:0];
		r.data_byte = db[7:0];
		r.last_byte = last;
		// a read of a page byte that was never written turns into an update of it
		if (op == OP_READ && sid < n_slots && s_used[sid] && idx < s_len[sid]) begin
			a = s_off[sid] + idx;
			if (a < PAGE && !pg_known[a]) r.opcode = OP_UPDATE;
		end
		stim_outcomes.insert(stim_outcomes.size(), page_model_step(r));
		stim_items.insert(stim_items.size(), r);
		n_items++;
	endtask

	task automatic queue_record(int len, int nbytes, bit close);
		for (int k = 0; k < nbytes; k++)
			queue_item(OP_INSERT, $urandom_range(0, 255), len, $urandom_range(0, 4095),
				$urandom_range(0, 255), close && k == nbytes - 1);
	endtask

	function automatic int pick_slot();
		if (n_slots > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, n_slots - 1);
		return $urandom_range(0, 255);
	endfunction

	function automatic int pick_index(int sid);
		if (sid < n_slots && s_len[sid] > 0 && $urandom_range(0, 9) != 0)
			return $urandom_range(0, s_len[sid] - 1);
		return $urandom_range(0, 4095);
	endfunction

	initial begin
		int sel, len, nb, sid;
		n_slots = 0;
		n_free = PAGE - HDR;
		wr_ptr = 0;
		open_slot = 0;
		ins_open = 1'b0;
		ins_refused = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			s_off[i] = 0;
			s_len[i] = 0;
			s_used[i] = 1'b0;
		end
		for (int i = 0; i < PAGE; i++) begin
			pg_mem[i] = 8'h00;
			pg_known[i] = 1'b0;
		end

		// directed part
		queue_item(OP_INSERT, 0, 0, 0, 0, 1'b1);
		queue_item(OP_INSERT, 255, 4, 4095, 8'hff, 1'b0);
		queue_item(OP_INSERT, 0, 4, 0, 8'h00, 1'b0);
		queue_item(OP_INSERT, 0, 4, 0, 8'h5a, 1'b0);
		queue_item(OP_INSERT, 0, 4, 0, 8'ha5, 1'b1);
		queue_record(2, 4, 1'b1);
		queue_record(5, 2, 1'b1);
		queue_record(4096, 3, 1'b1);
		queue_record(6, 2, 1'b0);
		queue_item(OP_READ, 1, 0, 3, 0, 1'b0);
		queue_item(OP_UPDATE, 1, 0, 0, 8'hff, 1'b0);
		queue_item(OP_READ, 1, 0, 0, 0, 1'b0);
		queue_item(OP_READ, 1, 0, 4095, 0, 1'b0);
		queue_item(OP_READ, 255, 0, 0, 0, 1'b0);
		queue_item(OP_ERASE, 1, 0, 0, 0, 1'b0);
		queue_item(OP_ERASE, 1, 0, 0, 0, 1'b0);
		queue_item(OP_UPDATE, 1, 0, 0, 0, 1'b0);
		queue_item(OP_ERASE, n_slots - 1, 0, 0, 0, 1'b0);
		queue_item(OP_READ, 2, 0, 1, 0, 1'b0);

		// random part
		while (n_items < 700) begin
			sel = $urandom_range(0, 99);
			if (n_free < 1200 && sel < 40) sel = 60;
			if (sel < 55) begin
				sel = $urandom_range(0, 99);
				if (sel < 5) len = 0;
				else if (sel < 15) len = $urandom_range(0, 8191);
				else if (sel < 18) len = 4096;
				else len = $urandom_range(1, 12);
				nb = len > 16 ? $urandom_range(1, 3) : len;
				sel = $urandom_range(0, 99);
				if (len == 0) queue_item(OP_INSERT, 0, 0, 0, $urandom_range(0, 255), 1'b1);
				else if (sel < 80) queue_record(len, nb, 1'b1);
				else if (sel < 88) queue_record(len, $urandom_range(1, nb), 1'b1);
				else if (sel < 94) queue_record(len, nb + $urandom_range(1, 3), 1'b1);
				else queue_record(len, $urandom_range(1, nb), 1'b0);
			end else if (sel < 72) begin
				queue_item(OP_ERASE, pick_slot(), $urandom_range(0, 8191),
					$urandom_range(0, 4095), $urandom_range(0, 255), $urandom_range(0, 1));
			end else begin
				sid = pick_slot();
				queue_item(sel < 85 ? OP_UPDATE : OP_READ, sid, $urandom_range(0, 8191),
					pick_index(sid), $urandom_range(0, 255), $urandom_range(0, 1));
			end
		end
		n_total = stim_items.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (stim_items.size() != 0 || req_ch.valid) @(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("[slotted_page_record_store] OK");
		else
			$display("[slotted_page_record_store] ERROR");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.payload <= '0;
			n_sent = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				outcome_q.insert(outcome_q.size(), offered_outcome);
				n_sent++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				idle_pct = n_sent * 3 < n_total ? 28 : (n_sent * 3 < 2 * n_total ? 49 : 0);
				if (stim_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
					req_ch.payload <= stim_items.pop_front();
					offered_outcome = stim_outcomes.pop_front();
					req_ch.valid <= 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor and response stalls
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int stall_pct;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			n_got = 0;
			fails = 0;
			idle_cycles = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_got++;
				if (outcome_q.size() == 0) begin
					fails++;
					if (fails <= 10) $display("unexpected result %p", rsp_ch.payload);
				end else begin
					want = outcome_q.pop_front();
					if (rsp_ch.payload.status !== want.status ||
					    rsp_ch.payload.result_slot !== want.result_slot ||
					    rsp_ch.payload.read_byte !== want.read_byte ||
					    rsp_ch.payload.free_bytes !== want.free_bytes ||
					    rsp_ch.payload.slot_total !== want.slot_total) begin
						fails++;
						if (fails <= 10)
							$display("result %0d mismatch: expected %p got %p",
								n_got, want, rsp_ch.payload);
					end
				end
			end
			if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[slotted_page_record_store] ERROR");
				$finish;
			end
			stall_pct = n_got * 3 < n_total ? 49 : (n_got * 3 < 2 * n_total ? 28 : 0);
			rsp_ch.ready <= $urandom_range(0, 99) >= stall_pct;
		end
	end

endmodule

@@ slotted_page_record_store.f @@
design/spr_pkg.sv
design/spr_req_if.sv
design/spr_rsp_if.sv
design/spr_scan.sv
design/slotted_page_record_store.sv
test/tb_slotted_page_record_store.sv
